FILE: src/packet_slot_ring_manager_top_defines.svh
// Assertion macros for the packet slot ring manager.
// Used by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef PACKET_SLOT_RING_MANAGER_TOP_DEFINES_SVH
`define PACKET_SLOT_RING_MANAGER_TOP_DEFINES_SVH

// check a property on every clock edge outside reset
`define PSRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition implies a consequence outside reset
`define PSRM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`endif

FILE: src/psrm_pkg.sv
// Shared types, constants and helper functions of the packet slot ring manager.
// No dependencies.
package psrm_pkg;

	localparam int MAX_SLOTS  = 16;
	localparam int HEAD_BYTES = 2;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int PTR_W      = $clog2(MAX_SLOTS + 1);
	localparam int CNT_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int OFFS_W     = 12;
	localparam int CFG_IDX_W  = 1;

	localparam logic [1:0] OP_RESERVE    = 2'd0;
	localparam logic [1:0] OP_TAKE_RX    = 2'd1;
	localparam logic [1:0] OP_TAKE_TX    = 2'd2;
	localparam logic [1:0] OP_SET_STATUS = 2'd3;

	localparam logic [1:0] ST_FREE    = 2'd0;
	localparam logic [1:0] ST_FILLING = 2'd1;
	localparam logic [1:0] ST_FILLED  = 2'd2;
	localparam logic [1:0] ST_SPI     = 2'd3;

	localparam logic [1:0] RC_OK       = 2'd0;
	localparam logic [1:0] RC_BUSY     = 2'd1;
	localparam logic [1:0] RC_OVERSIZE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 1'd1;

	localparam logic [CNT_W-1:0]  SLOT_COUNT_RST = 5'd16;
	localparam logic [BYTE_W-1:0] SLOT_BYTES_RST = 8'd64;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] request_bytes;
		logic [3:0] target_slot;
		logic [1:0] new_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic [3:0]  slot_index;
		logic [11:0] byte_offset;
		logic [7:0]  fill_bytes;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0]  slot_count;
		logic [BYTE_W-1:0] slot_bytes;
	} cfg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PEND
	} fsm_t;

	function automatic logic [SLOT_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p,
			input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] n;
		n = (cnt < CNT_W'(MAX_SLOTS)) ? cnt : CNT_W'(MAX_SLOTS);
		return (CNT_W'(p) >= n) ? '0 : p[SLOT_W-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] payload_cap(input logic [BYTE_W-1:0] sb);
		return (sb > BYTE_W'(HEAD_BYTES)) ? sb - BYTE_W'(HEAD_BYTES) : '0;
	endfunction

endpackage

FILE: src/psrm_vram.sv
// Synchronous RAM with one write and one registered read port.
// Entries never written since reset read as zero through per-entry valid flags.
module psrm_vram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem_q[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/psrm_engine.sv
// Slot ring sequencer: read-modify-write of the slot status and fill memories.
// Depends on psrm_pkg, psrm_vram and the assertion macro header.
`include "packet_slot_ring_manager_top_defines.svh"

module psrm_engine import psrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	input  logic out_free,
	output logic res_valid,
	output rsp_t res
);

	fsm_t fsm_q, fsm_d;
	cmd_t item_q;
	logic [PTR_W-1:0]  rx_q, rx_d, tx_q, tx_d;
	logic              open_valid_q, ov_d;
	logic [SLOT_W-1:0] open_slot_q, os_d;
	logic [BYTE_W-1:0] bytes_left_q, bl_d;
	logic [SLOT_W-1:0] pend_idx_q, pend_d;

	logic              cmd_acc;
	logic [SLOT_W-1:0] rd_addr;
	logic [1:0]        st_rdata;
	logic [BYTE_W-1:0] fl_rdata;
	logic              st_we, fl_we;
	logic [SLOT_W-1:0] st_waddr;
	logic [1:0]        st_wdata;

	logic [BYTE_W-1:0] cap, fill_f, cur_left, used;
	logic              oversize, close, need_open, open_ok;
	logic [SLOT_W-1:0] rx_s, tx_s, cur_slot;
	logic [1:0]        rx_st;
	logic [OFFS_W-1:0] prod, offs;

	assign cmd_stall = (fsm_q != S_IDLE);
	assign cmd_acc   = cmd_valid && (fsm_q == S_IDLE);
	assign rd_addr   = (cmd.operation == OP_TAKE_TX) ? wrap_ptr(tx_q, cfg.slot_count)
			: wrap_ptr(rx_q, cfg.slot_count);

	psrm_vram #(.DATA_W(2), .DEPTH(MAX_SLOTS)) u_state_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd_acc),
		.raddr (rd_addr),
		.rdata (st_rdata)
	);

	psrm_vram #(.DATA_W(BYTE_W), .DEPTH(MAX_SLOTS)) u_fill_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (fl_we),
		.waddr (open_slot_q),
		.wdata (fill_f),
		.re    (cmd_acc),
		.raddr (rd_addr),
		.rdata (fl_rdata)
	);

	assign cap       = payload_cap(cfg.slot_bytes);
	assign oversize  = item_q.request_bytes > cap;
	assign close     = open_valid_q && (bytes_left_q < item_q.request_bytes);
	assign need_open = !open_valid_q || close;
	assign rx_s      = wrap_ptr(rx_q, cfg.slot_count);
	assign tx_s      = wrap_ptr(tx_q, cfg.slot_count);
	assign rx_st     = (close && (rx_s == open_slot_q)) ? ST_FILLED : st_rdata;
	assign open_ok   = (rx_st == ST_FREE);
	assign fill_f    = (cfg.slot_bytes > bytes_left_q) ? cfg.slot_bytes - bytes_left_q : '0;
	assign cur_slot  = need_open ? rx_s : open_slot_q;
	assign cur_left  = need_open ? cap : bytes_left_q;
	assign used      = (cap >= cur_left) ? cap - cur_left : '0;
	assign prod      = {{BYTE_W{1'b0}}, cur_slot} * {{SLOT_W{1'b0}}, cfg.slot_bytes};
	assign offs      = prod + OFFS_W'(HEAD_BYTES) + {{(OFFS_W-BYTE_W){1'b0}}, used};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q        <= S_IDLE;
			rx_q         <= '0;
			tx_q         <= '0;
			open_valid_q <= 1'b0;
			open_slot_q  <= '0;
			bytes_left_q <= '0;
			pend_idx_q   <= '0;
		end else begin
			fsm_q        <= fsm_d;
			rx_q         <= rx_d;
			tx_q         <= tx_d;
			open_valid_q <= ov_d;
			open_slot_q  <= os_d;
			bytes_left_q <= bl_d;
			pend_idx_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			item_q <= cmd;
		end
	end

	always_comb begin
		fsm_d     = fsm_q;
		rx_d      = rx_q;
		tx_d      = tx_q;
		ov_d      = open_valid_q;
		os_d      = open_slot_q;
		bl_d      = bytes_left_q;
		pend_d    = pend_idx_q;
		st_we     = 1'b0;
		st_waddr  = rx_s;
		st_wdata  = ST_FILLING;
		fl_we     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		unique case (fsm_q)
			S_IDLE: begin
				if (cmd_acc) begin
					fsm_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					res_valid = 1'b1;
					fsm_d     = S_IDLE;
					unique case (item_q.operation)
						OP_RESERVE: begin
							if (oversize) begin
								res.result_code = RC_OVERSIZE;
								res.slot_index  = open_valid_q ? open_slot_q : '0;
							end else begin
								if (close) begin
									st_we    = 1'b1;
									st_waddr = open_slot_q;
									st_wdata = ST_FILLED;
									fl_we    = 1'b1;
									ov_d     = 1'b0;
								end
								if (need_open && !open_ok) begin
									res.result_code = RC_BUSY;
									res.slot_index  = rx_s;
								end else begin
									if (need_open) begin
										ov_d = 1'b1;
										os_d = rx_s;
										rx_d = {1'b0, rx_s} + PTR_W'(1);
										if (close) begin
											fsm_d  = S_PEND;
											pend_d = rx_s;
										end else begin
											st_we    = 1'b1;
											st_waddr = rx_s;
											st_wdata = ST_FILLING;
										end
									end
									bl_d            = cur_left - item_q.request_bytes;
									res.result_code = RC_OK;
									res.slot_index  = cur_slot;
									res.byte_offset = offs;
								end
							end
						end
						OP_TAKE_RX: begin
							res.slot_index = rx_s;
							if (st_rdata == ST_FREE) begin
								st_we    = 1'b1;
								st_waddr = rx_s;
								st_wdata = ST_FILLING;
								rx_d     = {1'b0, rx_s} + PTR_W'(1);
							end else begin
								res.result_code = RC_BUSY;
							end
						end
						OP_TAKE_TX: begin
							res.slot_index = tx_s;
							if (st_rdata == ST_FILLED) begin
								st_we          = 1'b1;
								st_waddr       = tx_s;
								st_wdata       = ST_SPI;
								tx_d           = {1'b0, tx_s} + PTR_W'(1);
								res.fill_bytes = fl_rdata;
							end else begin
								res.result_code = RC_BUSY;
							end
						end
						OP_SET_STATUS: begin
							res.slot_index = item_q.target_slot;
							st_we          = 1'b1;
							st_waddr       = item_q.target_slot;
							st_wdata       = item_q.new_status;
						end
						default: begin
							res = '0;
						end
					endcase
				end
			end
			S_PEND: begin
				st_we    = 1'b1;
				st_waddr = pend_idx_q;
				st_wdata = ST_FILLING;
				fsm_d    = S_IDLE;
			end
			default: begin
				fsm_d = S_IDLE;
			end
		endcase
	end

	`PSRM_ASSERT_IMPL(a_acc_to_exec, cmd_acc, ##1 (fsm_q == S_EXEC), "accepted beat did not start execution")
	`PSRM_ASSERT_IMPL(a_pend_is_open, fsm_q == S_PEND, open_valid_q && (pend_idx_q == open_slot_q), "pending status write does not target the open slot")
	`PSRM_ASSERT(a_ptr_range, (rx_q <= PTR_W'(MAX_SLOTS)) && (tx_q <= PTR_W'(MAX_SLOTS)), "ring pointer beyond slot range")

endmodule

FILE: src/packet_slot_ring_manager_top.sv
// Top level of the packet slot ring manager: configuration registers and result register.
// Depends on psrm_pkg and psrm_engine.
//
//   channel  direction  handshake             beat
//   cmd      in         cmd_valid / cmd_stall  cmd_t: operation, request_bytes, target_slot, new_status
//   rsp      out        rsp_valid / rsp_stall  rsp_t: result_code, slot_index, byte_offset, fill_bytes
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The status and fill memories are read when a command is accepted; the command then
// modifies and writes them back in S_EXEC. A reserve that closes the open slot and opens
// the next goes on to S_PEND for the second write to the single status memory port.
// After reset all slots read free at once; there is no clearing pass.
// A result held under rsp_stall leaves the next command accepted, but that command
// waits in its write-back cycle until the result register drains.
module packet_slot_ring_manager_top import psrm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	cfg_t cfg_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic out_free;
	logic res_valid;
	rsp_t res;

	assign cfg_ready = 1'b1;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_count <= SLOT_COUNT_RST;
			cfg_q.slot_bytes <= SLOT_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SLOT_COUNT: cfg_q.slot_count <= cfg_data[CNT_W-1:0];
				CFG_SLOT_BYTES: cfg_q.slot_bytes <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	psrm_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: tb/packet_slot_ring_manager_top_tb.sv
// Self-checking testbench for packet_slot_ring_manager_top.
// Tracks slot status, fill lengths and ring pointers to predict each response beat.
// Depends on psrm_pkg and the RTL under src/.
module packet_slot_ring_manager_top_tb;
	import psrm_pkg::*;

	localparam int ITEMS_PER_PHASE = 88;
	localparam int PHASES = 8;
	localparam int CYCLE_LIMIT = 300000;

	class slot_ring_tracker;
		logic [1:0] status_of [MAX_SLOTS];
		logic [7:0] length_of [MAX_SLOTS];
		int rx_next;
		int tx_next;
		int open_idx;
		int room_left;
		int count_reg;
		int bytes_reg;
		bit open_ok;
		rsp_t awaited [$];
		int failures;

		function new();
			for (int i = 0; i < MAX_SLOTS; i++) begin
				status_of[i] = ST_FREE;
				length_of[i] = '0;
			end
			rx_next = 0;
			tx_next = 0;
			open_idx = 0;
			room_left = 0;
			open_ok = 1'b0;
			count_reg = SLOT_COUNT_RST;
			bytes_reg = SLOT_BYTES_RST;
			failures = 0;
		endfunction

		function int wrap_slot(input int p);
			int n;
			n = (count_reg < MAX_SLOTS) ? count_reg : MAX_SLOTS;
			return (p >= n) ? 0 : p;
		endfunction

		function int payload_room();
			return (bytes_reg > HEAD_BYTES) ? bytes_reg - HEAD_BYTES : 0;
		endfunction

		function void set_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [BYTE_W-1:0] data);
			if (idx == CFG_SLOT_COUNT)
				count_reg = data[CNT_W-1:0];
			else
				bytes_reg = data;
		endfunction

		function void note_command(input cmd_t c);
			rsp_t r;
			int s;
			int room;
			int used;
			int req;
			bit granted;
			r = '0;
			room = payload_room();
			req = c.request_bytes;
			case (c.operation)
			OP_RESERVE: begin
				if (req > room) begin
					r.result_code = RC_OVERSIZE;
					r.slot_index = open_ok ? 4'(open_idx) : 4'd0;
				end else begin
					if (open_ok && room_left < req) begin
						status_of[open_idx] = ST_FILLED;
						length_of[open_idx] = 8'((bytes_reg > room_left) ?
							bytes_reg - room_left : 0);
						open_ok = 1'b0;
					end
					granted = 1'b1;
					if (!open_ok) begin
						s = wrap_slot(rx_next);
						r.slot_index = 4'(s);
						if (status_of[s] != ST_FREE) begin
							granted = 1'b0;
						end else begin
							status_of[s] = ST_FILLING;
							rx_next = s + 1;
							open_idx = s;
							open_ok = 1'b1;
							room_left = room;
						end
					end
					if (!granted) begin
						r.result_code = RC_BUSY;
					end else begin
						used = (room >= room_left) ? room - room_left : 0;
						r.slot_index = 4'(open_idx);
						r.byte_offset = OFFS_W'(open_idx * bytes_reg + HEAD_BYTES + used);
						room_left = (room_left - req) & 8'hFF;
					end
				end
			end
			OP_TAKE_RX: begin
				s = wrap_slot(rx_next);
				r.slot_index = 4'(s);
				if (status_of[s] == ST_FREE) begin
					status_of[s] = ST_FILLING;
					rx_next = s + 1;
				end else begin
					r.result_code = RC_BUSY;
				end
			end
			OP_TAKE_TX: begin
				s = wrap_slot(tx_next);
				r.slot_index = 4'(s);
				if (status_of[s] == ST_FILLED) begin
					status_of[s] = ST_SPI;
					tx_next = s + 1;
					r.fill_bytes = length_of[s];
				end else begin
					r.result_code = RC_BUSY;
				end
			end
			default: begin
				r.slot_index = c.target_slot;
				status_of[c.target_slot] = c.new_status;
			end
			endcase
			awaited.push_back(r);
		endfunction

		function void check_response(input rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response beat: code %0d slot %0d offset %0d fill %0d",
						got.result_code, got.slot_index, got.byte_offset, got.fill_bytes);
				return;
			end
			want = awaited.pop_front();
			if (got.result_code !== want.result_code || got.slot_index !== want.slot_index ||
					got.byte_offset !== want.byte_offset || got.fill_bytes !== want.fill_bytes) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected code %0d slot %0d offset %0d fill %0d, got code %0d slot %0d offset %0d fill %0d",
						want.result_code, want.slot_index, want.byte_offset, want.fill_bytes,
						got.result_code, got.slot_index, got.byte_offset, got.fill_bytes);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0] cfg_data = '0;

	int tx_gap_pct = 0;
	int rx_hold_pct = 0;
	int cycle_count = 0;
	int phase_slots [PHASES] = '{1, 16, 5, 2, 16, 9, 16, 3};
	int phase_bytes [PHASES] = '{3, 255, 40, 255, 3, 100, 64, 17};

	slot_ring_tracker ring = new();

	packet_slot_ring_manager_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rx_hold_pct);
	end

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			ring.note_command(cmd);
		if (arst_n && rsp_valid && !rsp_stall)
			ring.check_response(rsp);
	end

	function automatic cmd_t command_of(input logic [1:0] op, input int req, input int tgt,
			input logic [1:0] st);
		cmd_t c;
		c.operation = op;
		c.request_bytes = 8'(req);
		c.target_slot = 4'(tgt);
		c.new_status = st;
		return c;
	endfunction

	function automatic cmd_t pick_command();
		cmd_t c;
		int r;
		int room;
		room = ring.payload_room();
		c.operation = 2'($urandom);
		c.request_bytes = 8'($urandom);
		c.target_slot = 4'($urandom);
		c.new_status = 2'($urandom);
		r = $urandom_range(99);
		if (r < 45) begin
			c.operation = OP_RESERVE;
			r = $urandom_range(9);
			if (r < 5)
				c.request_bytes = 8'($urandom_range((room < 12) ? room : 12, 0));
			else if (r < 8)
				c.request_bytes = 8'($urandom_range(room, 0));
		end else if (r < 55) begin
			c.operation = OP_TAKE_RX;
		end else if (r < 75) begin
			c.operation = OP_TAKE_TX;
		end else begin
			c.operation = OP_SET_STATUS;
			if ($urandom_range(3) != 0) begin
				c.target_slot = 4'($urandom_range(ring.count_reg - 1, 0));
				c.new_status = ST_FREE;
			end
		end
		return c;
	endfunction

	task automatic send_command(input cmd_t c);
		while ($urandom_range(99) < tx_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (ring.awaited.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic configure(input int slots, input int bytes);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SLOT_COUNT;
		cfg_data <= BYTE_W'(slots);
		do @(posedge clk); while (!cfg_ready);
		ring.set_register(CFG_SLOT_COUNT, BYTE_W'(slots));
		cfg_index <= CFG_SLOT_BYTES;
		cfg_data <= BYTE_W'(bytes);
		do @(posedge clk); while (!cfg_ready);
		ring.set_register(CFG_SLOT_BYTES, BYTE_W'(bytes));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count = cycle_count + 1;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open, exhaust, oversize, close-and-reopen, takes, busy paths, releases
		send_command(command_of(OP_RESERVE, 0, 0, ST_FREE));
		send_command(command_of(OP_RESERVE, 62, 0, ST_FREE));
		send_command(command_of(OP_RESERVE, 255, 15, ST_SPI));
		send_command(command_of(OP_RESERVE, 1, 0, ST_FREE));
		send_command(command_of(OP_TAKE_TX, 0, 0, ST_FREE));
		send_command(command_of(OP_TAKE_TX, 255, 15, ST_SPI));
		send_command(command_of(OP_TAKE_RX, 0, 0, ST_FREE));
		send_command(command_of(OP_SET_STATUS, 0, 3, ST_FILLED));
		send_command(command_of(OP_RESERVE, 62, 0, ST_FREE));
		send_command(command_of(OP_RESERVE, 0, 0, ST_FREE));
		send_command(command_of(OP_TAKE_RX, 0, 0, ST_FREE));
		send_command(command_of(OP_SET_STATUS, 0, 3, ST_FREE));
		send_command(command_of(OP_SET_STATUS, 255, 15, ST_SPI));
		send_command(command_of(OP_SET_STATUS, 0, 0, ST_FILLING));
		send_command(command_of(OP_RESERVE, 5, 0, ST_FREE));
		send_command(command_of(OP_TAKE_TX, 0, 0, ST_FREE));
		send_command(command_of(OP_TAKE_TX, 0, 0, ST_FREE));
		send_command(command_of(OP_RESERVE, 63, 0, ST_FREE));
		send_command(command_of(OP_SET_STATUS, 0, 0, ST_FREE));
		send_command(command_of(OP_SET_STATUS, 0, 15, ST_FREE));
		send_command(command_of(OP_TAKE_RX, 0, 0, ST_FREE));
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				tx_gap_pct = 30;
				rx_hold_pct = 65;
			end else if (p < 6) begin
				tx_gap_pct = 65;
				rx_hold_pct = 30;
			end else begin
				tx_gap_pct = 0;
				rx_hold_pct = 0;
			end
			configure(phase_slots[p], phase_bytes[p]);
			repeat (ITEMS_PER_PHASE) send_command(pick_command());
			settle();
		end

		if (ring.failures == 0 && ring.awaited.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
